// ----- src/xncs_pkg.sv -----
// Shared types, constants and palette helpers for the xterm nearest color search.
package xncs_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } xncs_rgb_t;

    // Per-cycle command from the sequencer to the distance unit
    typedef struct packed {
        logic       start;
        logic       valid;
        logic       last;
        logic [7:0] index;
    } xncs_ctl_t;

    localparam logic        ACT_LOAD   = 1'b0;
    localparam logic        ACT_QUERY  = 1'b1;

    localparam logic [7:0]  CUBE_BASE  = 8'd16;
    localparam logic [7:0]  GREY_BASE  = 8'd232;
    localparam logic [7:0]  PAL_LAST   = 8'd255;
    localparam logic [7:0]  GREY_START = 8'd8;
    localparam logic [7:0]  GREY_STEP  = 8'd10;
    localparam logic [2:0]  CUBE_MAX   = 3'd5;
    localparam logic [17:0] DIST_START = 18'd195076;
    localparam logic [17:0] DIST_MAX   = 18'd195075;

    // Channel level of cube coordinate k: zero, else 55 + 40k
    function automatic logic [7:0] cube_level(input logic [2:0] k);
        logic [7:0] lvl;
        case (k)
            3'd0:    lvl = 8'd0;
            3'd1:    lvl = 8'd95;
            3'd2:    lvl = 8'd135;
            3'd3:    lvl = 8'd175;
            3'd4:    lvl = 8'd215;
            3'd5:    lvl = 8'd255;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- src/xncs_dist.sv -----
// Pipelined squared-distance unit with running minimum over a palette scan.
module xncs_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  xncs_pkg::xncs_ctl_t ctl,
    input  xncs_pkg::xncs_rgb_t cand,
    input  xncs_pkg::xncs_rgb_t query,
    output logic              done,
    output logic [7:0]        best_index,
    output logic [17:0]       best_dist
);
    import xncs_pkg::*;

    // stage 1: channel differences
    logic        s1_valid_reg;
    logic        s1_last_reg;
    logic [7:0]  s1_index_reg;
    logic [7:0]  s1_dr_reg, s1_dg_reg, s1_db_reg;
    // stage 2: squares
    logic        s2_valid_reg;
    logic        s2_last_reg;
    logic [7:0]  s2_index_reg;
    logic [15:0] s2_sr_reg, s2_sg_reg, s2_sb_reg;
    // stage 3: sum and compare
    logic [17:0] sum;
    logic [17:0] best_dist_reg;
    logic [7:0]  best_index_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.valid;
            s1_last_reg  <= ctl.valid & ctl.last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg & s1_last_reg;
            done_reg     <= s2_valid_reg & s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= ctl.index;
        s1_dr_reg    <= abs_diff(query.red, cand.red);
        s1_dg_reg    <= abs_diff(query.green, cand.green);
        s1_db_reg    <= abs_diff(query.blue, cand.blue);
        s2_index_reg <= s1_index_reg;
        s2_sr_reg    <= s1_dr_reg * s1_dr_reg;
        s2_sg_reg    <= s1_dg_reg * s1_dg_reg;
        s2_sb_reg    <= s1_db_reg * s1_db_reg;
    end

    assign sum = 18'(s2_sr_reg) + 18'(s2_sg_reg) + 18'(s2_sb_reg);

    // Strict less-than keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            best_dist_reg  <= DIST_START;
            best_index_reg <= '0;
        end
        else if (s2_valid_reg && (sum < best_dist_reg))
        begin
            best_dist_reg  <= sum;
            best_index_reg <= s2_index_reg;
        end
    end

    assign done       = done_reg;
    assign best_index = best_index_reg;
    assign best_dist  = best_dist_reg;

endmodule

// ----- src/xterm_nearest_color_search.sv -----
// Top level: xterm 256-color nearest match with loadable system colors.
// A load transfer (tuser = 0) writes one of the 16 system colors and gives no
// result; slots at or above SYSTEM_COLORS are ignored and those indices search as black.
// A query transfer (tuser = 1) scans palette indices 0 to 255, one per cycle, through a
// three-stage distance unit (difference, square, sum and compare); s_tready stays low
// until the result has been moved to the output register, so a new query is taken only
// after the last one is through. If the previous result still waits in the output
// register, the new one holds and s_tready stays low until m_tready takes the old one. The
// cube and grey ramp entries are generated by counters, not stored. The system table resets
// to black. The result sits in an output register, so the next transfer is taken while it
// waits.
module xterm_nearest_color_search #(
    parameter int SYSTEM_COLORS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // slot[3:0], red[11:4], green[19:12], blue[27:20], zero
    input  logic        s_tuser,  // action (0 load, 1 query)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // color_index[7:0], best_distance[25:8], zero
);
    import xncs_pkg::*;

    localparam logic [8:0] SYS_LIMIT  = 9'(SYSTEM_COLORS);
    localparam logic [4:0] SLOT_LIMIT = 5'(SYSTEM_COLORS);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_OUT} state_t;

    state_t      state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic [17:0] out_dist_reg, out_dist_next;

    logic [3:0]  in_slot;
    xncs_rgb_t   in_color;
    logic        in_xfer;
    logic        load_xfer;
    logic        query_xfer;

    xncs_rgb_t   pal_reg [16];
    xncs_rgb_t   query_reg;
    logic [7:0]  idx_reg;
    logic [2:0]  cr_reg, cg_reg, cb_reg;
    logic [7:0]  grey_reg;
    logic        in_cube;
    xncs_rgb_t   cand;
    xncs_ctl_t   ctl;

    logic        dist_done;
    logic [7:0]  dist_index;
    logic [17:0] dist_value;

    assign in_slot        = s_tdata[3:0];
    assign in_color.red   = s_tdata[11:4];
    assign in_color.green = s_tdata[19:12];
    assign in_color.blue  = s_tdata[27:20];

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_xfer    = s_tvalid & s_tready;
    assign load_xfer  = in_xfer & (s_tuser == ACT_LOAD);
    assign query_xfer = in_xfer & (s_tuser == ACT_QUERY);

    // System color table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pal_reg[i] <= '0;
            end
        end
        else if (load_xfer && ({1'b0, in_slot} < SLOT_LIMIT))
        begin
            pal_reg[in_slot] <= in_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            query_reg <= in_color;
        end
    end

    // Scan index and palette generators
    assign in_cube = (idx_reg >= CUBE_BASE) && (idx_reg < GREY_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cr_reg   <= '0;
            cg_reg   <= '0;
            cb_reg   <= '0;
            grey_reg <= GREY_START;
        end
        else if (query_xfer)
        begin
            idx_reg  <= '0;
            cr_reg   <= '0;
            cg_reg   <= '0;
            cb_reg   <= '0;
            grey_reg <= GREY_START;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + 8'd1;
            if (in_cube)
            begin
                if (cb_reg == CUBE_MAX)
                begin
                    cb_reg <= '0;
                    if (cg_reg == CUBE_MAX)
                    begin
                        cg_reg <= '0;
                        cr_reg <= cr_reg + 3'd1;
                    end
                    else
                    begin
                        cg_reg <= cg_reg + 3'd1;
                    end
                end
                else
                begin
                    cb_reg <= cb_reg + 3'd1;
                end
            end
            else if (idx_reg >= GREY_BASE)
            begin
                grey_reg <= grey_reg + GREY_STEP;
            end
        end
    end

    always_comb
    begin
        if (idx_reg < CUBE_BASE)
        begin
            cand = ({1'b0, idx_reg} < SYS_LIMIT) ? pal_reg[idx_reg[3:0]] : '0;
        end
        else if (in_cube)
        begin
            cand.red   = cube_level(cr_reg);
            cand.green = cube_level(cg_reg);
            cand.blue  = cube_level(cb_reg);
        end
        else
        begin
            cand.red   = grey_reg;
            cand.green = grey_reg;
            cand.blue  = grey_reg;
        end
    end

    assign ctl.start = query_xfer;
    assign ctl.valid = (state_reg == ST_SCAN);
    assign ctl.last  = (idx_reg == PAL_LAST);
    assign ctl.index = idx_reg;

    xncs_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cand       (cand),
        .query      (query_reg),
        .done       (dist_done),
        .best_index (dist_index),
        .best_dist  (dist_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_index_next = out_index_reg;
        out_dist_next  = out_dist_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == PAL_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dist_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the previous result has been taken
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_index_next = dist_index;
                    out_dist_next  = dist_value;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            out_index_reg <= '0;
            out_dist_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            out_index_reg <= out_index_next;
            out_dist_reg  <= out_dist_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_dist_reg, out_index_reg};

endmodule

// ----- src/xncs_checker.sv -----
// Port-level checks for the xterm nearest color search, bound to the top level.
module xncs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import xncs_pkg::*;

    logic in_xfer;
    assign in_xfer = s_tvalid & s_tready;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No distance beyond the largest possible one, padding stays zero
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:8] <= DIST_MAX) && (m_tdata[31:26] == 6'd0))
        else $error("distance out of range");

    // A query occupies the block, a load does not
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_tuser == ACT_QUERY) |=> !s_tready ##1 !s_tready)
        else $error("ready during a search");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_tuser == ACT_LOAD) |=> s_tready)
        else $error("load stalled input");

endmodule

bind xterm_nearest_color_search xncs_checker u_xncs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
